// ----- rtl/tpr_pkg.sv -----
// Shared types, constants and arithmetic helpers for the two-pole resonator bank.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tpr_pkg;

	// Default sizes of the bank
	localparam int FILTERS_DEF  = 1024;
	localparam int VEC_LOG2_DEF = 6;

	// Field widths
	localparam int COEF_W   = 26;
	localparam int SMP_W    = 24;
	localparam int IDX_W    = 10;
	localparam int ST_W     = 32;
	// Running coefficients may step slightly past their targets
	localparam int RC_W     = 28;
	localparam int INC_W    = 29;
	localparam int PROD_W   = RC_W + ST_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int RND_SH   = 22;
	localparam int RND_W    = ACC_W - RND_SH;
	localparam int SATIN_W  = RND_W + 1;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_KICK   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DISP,
		ST_LOAD,
		ST_K_RD,
		ST_K_MUL,
		ST_K_WR,
		ST_S_RD,
		ST_S_B1,
		ST_S_B2,
		ST_S_A1,
		ST_S_ACC,
		ST_S_RND,
		ST_S_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_B1,
		MUL_B2,
		MUL_A1,
		MUL_KICK
	} mul_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		logic     idx_clear;
		logic     idx_step;
		logic     addr_load;
		logic     clr_wr;
		logic     load_wr;
		mul_sel_t mul_sel;
		logic     inc_cap;
		logic     acc_start;
		logic     acc_add;
		logic     rnd;
		logic     smp_wr;
		logic     kick_wr;
		logic     out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic cnt_zero;
		logic idx_last;
		logic clr_last;
		logic out_busy;
	} dp_sts_t;

	// Add half an LSB and drop 22 fraction bits (floor)
	function automatic logic signed [RND_W-1:0] rnd22(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		begin
			t = v + (ACC_W'(1) <<< (RND_SH - 1));
			return t[ACC_W-1:RND_SH];
		end
	endfunction

	// Saturate to a 32-bit state value
	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SATIN_W-1:0] v);
		logic signed [SATIN_W-1:0] hi;
		logic signed [SATIN_W-1:0] lo;
		begin
			hi = SATIN_W'({1'b0, {(ST_W-1){1'b1}}});
			lo = -hi - SATIN_W'(1);
			if (v > hi)
				return {1'b0, {(ST_W-1){1'b1}}};
			else if (v < lo)
				return {1'b1, {(ST_W-1){1'b0}}};
			else
				return v[ST_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/tpr_ctrl.sv -----
// Sequencer for the resonator bank: walks filters for sample, kick and clear requests.
// Depends on tpr_pkg.
`default_nettype none

module tpr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire tpr_pkg::dp_sts_t sts,
	output tpr_pkg::dp_cmd_t      dcmd
);
	import tpr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register; reset starts the state clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		dcmd      = '0;
		dcmd.mul_sel = MUL_B1;
		unique case (state_q)
			ST_CLR: begin
				dcmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end else begin
					dcmd.idx_step = 1'b1;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dcmd.capture = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				dcmd.idx_clear = 1'b1;
				unique case (sts.cmd)
					CMD_LOAD:   state_d = ST_LOAD;
					CMD_CLEAR:  state_d = ST_CLR;
					CMD_KICK:   state_d = sts.cnt_zero ? ST_IDLE : ST_K_RD;
					CMD_SAMPLE: state_d = sts.cnt_zero ? ST_DONE : ST_S_RD;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_LOAD: begin
				dcmd.addr_load = 1'b1;
				dcmd.load_wr   = 1'b1;
				state_d = ST_IDLE;
			end
			ST_K_RD: begin
				state_d = ST_K_MUL;
			end
			ST_K_MUL: begin
				dcmd.mul_sel = MUL_KICK;
				state_d = ST_K_WR;
			end
			ST_K_WR: begin
				dcmd.kick_wr  = 1'b1;
				dcmd.idx_step = 1'b1;
				state_d = sts.idx_last ? ST_IDLE : ST_K_RD;
			end
			ST_S_RD: begin
				state_d = ST_S_B1;
			end
			ST_S_B1: begin
				dcmd.mul_sel = MUL_B1;
				dcmd.inc_cap = 1'b1;
				state_d = ST_S_B2;
			end
			ST_S_B2: begin
				dcmd.mul_sel   = MUL_B2;
				dcmd.acc_start = 1'b1;
				state_d = ST_S_A1;
			end
			ST_S_A1: begin
				dcmd.mul_sel = MUL_A1;
				dcmd.acc_add = 1'b1;
				state_d = ST_S_ACC;
			end
			ST_S_ACC: begin
				dcmd.acc_add = 1'b1;
				state_d = ST_S_RND;
			end
			ST_S_RND: begin
				dcmd.rnd = 1'b1;
				state_d = ST_S_WR;
			end
			ST_S_WR: begin
				dcmd.smp_wr   = 1'b1;
				dcmd.idx_step = 1'b1;
				state_d = sts.idx_last ? ST_DONE : ST_S_RD;
			end
			ST_DONE: begin
				// Hold the sum until the output register frees up
				if (!sts.out_busy) begin
					dcmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A taken request is always dispatched next
	a_capture_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DISP))
		else $error("accepted request not dispatched");

	// Only the idle state takes requests
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == ST_IDLE && !dcmd.smp_wr && !dcmd.kick_wr))
		else $error("request taken while busy");

	// A finished sum never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/tpr_dp.sv -----
// Datapath of the resonator bank: per-filter stores, shared multiplier, accumulators.
// Depends on tpr_pkg and tpr_ram.
`default_nettype none

module tpr_dp #(
	parameter int FILTERS  = tpr_pkg::FILTERS_DEF,
	parameter int VEC_LOG2 = tpr_pkg::VEC_LOG2_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tpr_pkg::dp_cmd_t                  dcmd,
	output tpr_pkg::dp_sts_t                       sts,
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_wr_data,
	input  wire logic [1:0]                        cmd,
	input  wire logic [tpr_pkg::IDX_W-1:0]         entry_index,
	input  wire logic                              last_entry,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] feedback_one,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] feedback_two,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] input_gain,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] kick_gain,
	input  wire logic signed [tpr_pkg::SMP_W-1:0]  sample_in,
	input  wire logic signed [tpr_pkg::SMP_W-1:0]  kick_amount,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output logic signed [tpr_pkg::ST_W-1:0]        sum_out
);
	import tpr_pkg::*;

	localparam int AW      = FILTERS > 1 ? $clog2(FILTERS) : 1;
	localparam int CNT_W   = $clog2(FILTERS + 1);
	localparam int POS_W   = VEC_LOG2 > 0 ? VEC_LOG2 : 1;
	localparam int SUM_W   = ST_W + CNT_W + 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'((1 << VEC_LOG2) - 1);
	localparam int TGT_W   = 3 * COEF_W;
	localparam int RCS_W   = 3 * RC_W;
	localparam int INCS_W  = 3 * INC_W;

	// Captured request
	cmd_t                     cmd_q;
	logic [IDX_W-1:0]         entry_index_q;
	logic                     last_entry_q;
	logic signed [COEF_W-1:0] b1_in_q, b2_in_q, a1_in_q, kg_in_q;
	logic signed [SMP_W-1:0]  x_q, amt_q;

	// Control and bookkeeping
	logic                     conn_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         i_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     out_valid_q;
	logic signed [ST_W-1:0]   sum_out_q;

	// Arithmetic registers
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ST_W-1:0]   y_q;
	logic signed [INC_W-1:0]  inc_b1_q, inc_b2_q, inc_a1_q;

	// Memory ports
	logic [AW-1:0]     addr;
	logic [TGT_W-1:0]  tgt_rd;
	logic [COEF_W-1:0] kg_rd;
	logic [RCS_W-1:0]  rc_rd, rc_wd;
	logic [INCS_W-1:0] inc_rd, inc_wd;
	logic [2*ST_W-1:0] st_rd, st_wd;
	logic              tgt_we, rc_we, inc_we, st_we;

	logic load_ok, load_new;
	logic signed [COEF_W-1:0] t_b1, t_b2, t_a1, kg;
	logic signed [RC_W-1:0]   rc_b1, rc_b2, rc_a1;
	logic signed [INC_W-1:0]  ri_b1, ri_b2, ri_a1;
	logic signed [ST_W-1:0]   y1, y2;
	logic signed [RC_W-1:0]   ma;
	logic signed [ST_W-1:0]   mb;
	logic signed [RND_W-1:0]  kick_add;
	logic signed [ST_W-1:0]   y2_kick;
	logic signed [INC_W-1:0]  nb1, nb2, na1;
	logic [RCS_W-1:0]         rc_new;
	logic signed [SUM_W-1:0]  sum_hi, sum_lo;

	assign addr = dcmd.addr_load ? AW'(entry_index_q) : i_q[AW-1:0];

	// Unpack read data
	assign {t_a1, t_b2, t_b1}    = tgt_rd;
	assign kg                    = kg_rd;
	assign {rc_a1, rc_b2, rc_b1} = rc_rd;
	assign {ri_a1, ri_b2, ri_b1} = inc_rd;
	assign {y2, y1}              = st_rd;

	assign load_ok  = ({22'd0, entry_index_q} < 32'(FILTERS));
	assign load_new = ({22'd0, entry_index_q} >= 32'(cnt_q));

	// Request capture
	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			cmd_q         <= cmd_t'(cmd);
			entry_index_q <= entry_index;
			last_entry_q  <= last_entry;
			b1_in_q       <= feedback_one;
			b2_in_q       <= feedback_two;
			a1_in_q       <= input_gain;
			kg_in_q       <= kick_gain;
			x_q           <= sample_in;
			amt_q         <= kick_amount;
		end
	end

	// Config register, count, position, loop index, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q      <= 1'b1;
			cnt_q       <= '0;
			pos_q       <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				conn_q <= cfg_wr_data;
			end
			if (dcmd.load_wr && load_ok && last_entry_q) begin
				cnt_q <= CNT_W'({22'd0, entry_index_q} + 32'd1);
			end
			if (dcmd.idx_clear) begin
				i_q <= '0;
			end else if (dcmd.idx_step) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (dcmd.out_load) begin
				out_valid_q <= 1'b1;
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Shared multiplier operand select
	always_comb begin
		unique case (dcmd.mul_sel)
			MUL_B1: begin
				ma = rc_b1;
				mb = y1;
			end
			MUL_B2: begin
				ma = rc_b2;
				mb = y2;
			end
			MUL_A1: begin
				ma = conn_q ? rc_a1 : '0;
				mb = ST_W'(x_q);
			end
			MUL_KICK: begin
				ma = RC_W'(kg);
				mb = ST_W'(amt_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Multiply, accumulate, round
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (dcmd.acc_start) begin
			acc_q <= {{2{prod_q[PROD_W-1]}}, prod_q};
		end else if (dcmd.acc_add) begin
			acc_q <= acc_q + {{2{prod_q[PROD_W-1]}}, prod_q};
		end
		if (dcmd.rnd) begin
			y_q <= sat_st(SATIN_W'(rnd22(acc_q)));
		end
		// Per-vector increments are taken at the vector start
		if (dcmd.inc_cap) begin
			if (pos_q == '0) begin
				inc_b1_q <= (INC_W'(t_b1) - INC_W'(rc_b1)) >>> VEC_LOG2;
				inc_b2_q <= (INC_W'(t_b2) - INC_W'(rc_b2)) >>> VEC_LOG2;
				inc_a1_q <= (INC_W'(t_a1) - INC_W'(rc_a1)) >>> VEC_LOG2;
			end else begin
				inc_b1_q <= ri_b1;
				inc_b2_q <= ri_b2;
				inc_a1_q <= ri_a1;
			end
		end
		if (dcmd.idx_clear) begin
			sum_q <= '0;
		end else if (dcmd.smp_wr) begin
			sum_q <= sum_q + SUM_W'(y_q);
		end
		if (dcmd.out_load) begin
			sum_out_q <= (sum_q > sum_hi) ? ST_W'(sum_hi)
				: (sum_q < sum_lo) ? ST_W'(sum_lo) : sum_q[ST_W-1:0];
		end
	end

	assign sum_hi = SUM_W'({1'b0, {(ST_W-1){1'b1}}});
	assign sum_lo = -sum_hi - SUM_W'(1);

	// Kick: round the product, add to y2, saturate
	assign kick_add = rnd22({{2{prod_q[PROD_W-1]}}, prod_q});
	assign y2_kick  = sat_st(SATIN_W'(y2) + {kick_add[RND_W-1], kick_add});

	// Ramp step, or snap to targets at the vector end; a1 is held while the input is disconnected
	assign nb1 = INC_W'(rc_b1) + inc_b1_q;
	assign nb2 = INC_W'(rc_b2) + inc_b2_q;
	assign na1 = INC_W'(rc_a1) + inc_a1_q;
	always_comb begin
		if (pos_q == POS_LAST) begin
			rc_new = {conn_q ? RC_W'(t_a1) : rc_a1, RC_W'(t_b2), RC_W'(t_b1)};
		end else begin
			rc_new = {conn_q ? na1[RC_W-1:0] : rc_a1, nb2[RC_W-1:0], nb1[RC_W-1:0]};
		end
	end

	// Write selection
	always_comb begin
		tgt_we = dcmd.load_wr && load_ok;
		rc_we  = (dcmd.load_wr && load_ok && load_new) || dcmd.smp_wr;
		inc_we = rc_we;
		st_we  = rc_we || dcmd.clr_wr || dcmd.kick_wr;
		if (dcmd.smp_wr) begin
			rc_wd  = rc_new;
			inc_wd = {inc_a1_q, inc_b2_q, inc_b1_q};
			st_wd  = {y1, y_q};
		end else begin
			rc_wd  = {RC_W'(0), RC_W'(b2_in_q), RC_W'(b1_in_q)};
			inc_wd = '0;
			st_wd  = dcmd.kick_wr ? {y2_kick, y1} : '0;
		end
	end

	tpr_ram #(.WIDTH(TGT_W), .DEPTH(FILTERS)) u_tgt_ram (
		.clk(clk), .we(tgt_we), .waddr(addr), .wdata({a1_in_q, b2_in_q, b1_in_q}),
		.raddr(addr), .rdata(tgt_rd));

	tpr_ram #(.WIDTH(COEF_W), .DEPTH(FILTERS)) u_kg_ram (
		.clk(clk), .we(tgt_we), .waddr(addr), .wdata(kg_in_q),
		.raddr(addr), .rdata(kg_rd));

	tpr_ram #(.WIDTH(RCS_W), .DEPTH(FILTERS)) u_rc_ram (
		.clk(clk), .we(rc_we), .waddr(addr), .wdata(rc_wd),
		.raddr(addr), .rdata(rc_rd));

	tpr_ram #(.WIDTH(INCS_W), .DEPTH(FILTERS)) u_inc_ram (
		.clk(clk), .we(inc_we), .waddr(addr), .wdata(inc_wd),
		.raddr(addr), .rdata(inc_rd));

	tpr_ram #(.WIDTH(2 * ST_W), .DEPTH(FILTERS)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(addr), .wdata(st_wd),
		.raddr(addr), .rdata(st_rd));

	// Status
	assign sts.cmd      = cmd_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.idx_last = (CNT_W'(i_q + CNT_W'(1)) == cnt_q);
	assign sts.clr_last = (i_q == CNT_W'(FILTERS - 1));
	assign sts.out_busy = out_valid_q && !res_ready;

	assign res_valid = out_valid_q;
	assign sum_out   = sum_out_q;

	// Active count never exceeds the bank size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= FILTERS)
		else $error("active count out of range");

	// Filter updates only touch active entries
	a_upd_active: assert property (@(posedge clk) disable iff (!arst_n)
		(dcmd.smp_wr || dcmd.kick_wr) |-> (i_q < cnt_q))
		else $error("update of inactive entry");

	// The loop index is cleared before each walk over the filters
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.idx_clear |=> (i_q == '0))
		else $error("loop index not cleared");

endmodule

`default_nettype wire

// ----- rtl/two_pole_resonator_bank.sv -----
// Top level of the two-pole resonator bank: controller plus datapath.
// Depends on tpr_pkg, tpr_ctrl, tpr_dp (and tpr_ram through tpr_dp).
//
//  channel   signals                         accepted when
//  request   req_valid/req_ready + fields    req_valid && req_ready
//  result    res_valid/res_ready, sum_out    res_valid && res_ready
//  config    cfg_wr_en, cfg_wr_data          cfg_wr_en
//
// Sample request: one active filter at a time through the shared multiplier
// (three products per filter) and the per-entry RAMs. A kick walks the active
// filters, a load writes one entry and a clear sweeps all FILTERS entries.
// After reset all FILTERS filter states are swept to zero, with req_ready low.
// A new request is taken while a sum waits in the result register; a later sum
// waits in its final state until that register is taken.
`default_nettype none

module two_pole_resonator_bank #(
	parameter int FILTERS  = tpr_pkg::FILTERS_DEF,
	parameter int VEC_LOG2 = tpr_pkg::VEC_LOG2_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_wr_data,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire logic [1:0]                        cmd,
	input  wire logic [tpr_pkg::IDX_W-1:0]         entry_index,
	input  wire logic                              last_entry,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] feedback_one,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] feedback_two,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] input_gain,
	input  wire logic signed [tpr_pkg::COEF_W-1:0] kick_gain,
	input  wire logic signed [tpr_pkg::SMP_W-1:0]  sample_in,
	input  wire logic signed [tpr_pkg::SMP_W-1:0]  kick_amount,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output logic signed [tpr_pkg::ST_W-1:0]        sum_out
);
	import tpr_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t sts;

	tpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.sts(sts), .dcmd(dcmd));

	tpr_dp #(.FILTERS(FILTERS), .VEC_LOG2(VEC_LOG2)) u_dp (
		.clk(clk), .arst_n(arst_n), .dcmd(dcmd), .sts(sts),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.cmd(cmd), .entry_index(entry_index), .last_entry(last_entry),
		.feedback_one(feedback_one), .feedback_two(feedback_two),
		.input_gain(input_gain), .kick_gain(kick_gain),
		.sample_in(sample_in), .kick_amount(kick_amount),
		.res_valid(res_valid), .res_ready(res_ready), .sum_out(sum_out));

endmodule

`default_nettype wire

// ----- dv/two_pole_resonator_bank_tb.sv -----
// Self-checking testbench for the two-pole resonator bank.
// Depends on tpr_pkg and the two_pole_resonator_bank RTL; drives requests and
// checks each summed output against an in-bench model of the filter bank.
`timescale 1ns / 1ps

module two_pole_resonator_bank_tb;
	import tpr_pkg::*;

	localparam int NFILT = 1024;
	localparam int VLOG = 6;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		cmd_t                     op;
		logic [IDX_W-1:0]         idx;
		logic                     last;
		logic signed [COEF_W-1:0] b1, b2, a1, kg;
		logic signed [SMP_W-1:0]  x, amt;
	} bank_req_t;

	logic clk, arst_n;
	logic cfg_wr_en, cfg_wr_data;
	logic req_valid, req_ready;
	logic [1:0] cmd;
	logic [IDX_W-1:0] entry_index;
	logic last_entry;
	logic signed [COEF_W-1:0] feedback_one, feedback_two, input_gain, kick_gain;
	logic signed [SMP_W-1:0] sample_in, kick_amount;
	logic res_valid, res_ready;
	logic signed [ST_W-1:0] sum_out;

	two_pole_resonator_bank dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_ready(req_ready),
		.cmd(cmd), .entry_index(entry_index), .last_entry(last_entry),
		.feedback_one(feedback_one), .feedback_two(feedback_two),
		.input_gain(input_gain), .kick_gain(kick_gain),
		.sample_in(sample_in), .kick_amount(kick_amount),
		.res_valid(res_valid), .res_ready(res_ready), .sum_out(sum_out)
	);

	// Bank model state
	longint tgt_b1[NFILT], tgt_b2[NFILT], tgt_a1[NFILT], kick_g[NFILT];
	longint run_c[NFILT][3], step_c[NFILT][3];
	longint y_one[NFILT], y_two[NFILT];
	bit     loaded[NFILT];
	int unsigned n_active, vec_pos;
	bit     connected;

	logic signed [ST_W-1:0] expected_sums[$];
	int errors;
	int burst_left;
	int hold_cycles;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Q..45 -> Q..23 with round half up, then saturate
	function automatic longint to_state(longint acc);
		return sat32((acc + (64'sd1 <<< 21)) >>> 22);
	endfunction

	// Advance the bank model by one accepted request
	function automatic void bank_apply(bank_req_t r);
		longint sum, acc, y, x, amt;
		int i;
		case (r.op)
			CMD_LOAD: begin
				i = r.idx;
				tgt_b1[i] = r.b1;
				tgt_b2[i] = r.b2;
				tgt_a1[i] = r.a1;
				kick_g[i] = r.kg;
				loaded[i] = 1'b1;
				if (i >= n_active) begin
					run_c[i][0] = tgt_b1[i];
					run_c[i][1] = tgt_b2[i];
					run_c[i][2] = 0;
					for (int k = 0; k < 3; k++) step_c[i][k] = 0;
					y_one[i] = 0;
					y_two[i] = 0;
				end
				if (r.last) n_active = i + 1;
			end
			CMD_KICK: begin
				amt = r.amt;
				for (i = 0; i < n_active; i++)
					y_two[i] = sat32(y_two[i] + ((kick_g[i] * amt + (64'sd1 <<< 21)) >>> 22));
			end
			CMD_CLEAR: begin
				for (i = 0; i < NFILT; i++) begin
					y_one[i] = 0;
					y_two[i] = 0;
				end
			end
			default: begin
				x = r.x;
				sum = 0;
				for (i = 0; i < n_active; i++) begin
					if (vec_pos == 0) begin
						step_c[i][0] = (tgt_b1[i] - run_c[i][0]) >>> VLOG;
						step_c[i][1] = (tgt_b2[i] - run_c[i][1]) >>> VLOG;
						step_c[i][2] = (tgt_a1[i] - run_c[i][2]) >>> VLOG;
					end
					acc = run_c[i][0] * y_one[i] + run_c[i][1] * y_two[i];
					if (connected) acc += run_c[i][2] * x;
					y = to_state(acc);
					y_two[i] = y_one[i];
					y_one[i] = y;
					sum += y;
					if (vec_pos == (1 << VLOG) - 1) begin
						run_c[i][0] = tgt_b1[i];
						run_c[i][1] = tgt_b2[i];
						if (connected) run_c[i][2] = tgt_a1[i];
					end else begin
						run_c[i][0] += step_c[i][0];
						run_c[i][1] += step_c[i][1];
						if (connected) run_c[i][2] += step_c[i][2];
					end
				end
				vec_pos = (vec_pos + 1) % (1 << VLOG);
				expected_sums.push_back(ST_W'(sat32(sum)));
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	// Send one request; returns at the edge where it is accepted
	task automatic send_request(bank_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid    <= 1'b1;
		cmd          <= r.op;
		entry_index  <= r.idx;
		last_entry   <= r.last;
		feedback_one <= r.b1;
		feedback_two <= r.b2;
		input_gain   <= r.a1;
		kick_gain    <= r.kg;
		sample_in    <= r.x;
		kick_amount  <= r.amt;
		do @(posedge clk); while (!req_ready);
		bank_apply(r);
	endtask

	// Random coefficient: mostly moderate, sometimes full range
	function automatic logic signed [COEF_W-1:0] rand_coef();
		if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
		return COEF_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
	endfunction

	function automatic bank_req_t rand_fields(cmd_t op);
		bank_req_t r;
		r.op = op;
		r.idx = IDX_W'($urandom);
		r.last = 1'b0;
		r.b1 = rand_coef();
		r.b2 = rand_coef();
		r.a1 = rand_coef();
		r.kg = rand_coef();
		r.x = SMP_W'($urandom);
		r.amt = SMP_W'($urandom);
		return r;
	endfunction

	// Well-formed coefficient list 0..len-1, count set by the final entry
	task automatic load_list(int len);
		bank_req_t r;
		for (int i = 0; i < len; i++) begin
			r = rand_fields(CMD_LOAD);
			r.idx = i;
			r.last = (i == len - 1);
			send_request(r);
		end
	endtask

	// Stop sending, wait for all sums, then cover any request still in progress
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (8 * n_active + NFILT + 16) @(posedge clk);
	endtask

	task automatic set_input_connected(bit v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		connected = v;
	endtask

	// Field extremes, each command, new entry, retarget, shrink, clear
	task automatic test_directed();
		bank_req_t r;
		r = rand_fields(CMD_LOAD);
		r.idx = 0; r.b1 = 26'sh1ffffff; r.b2 = -26'sh2000000; r.a1 = 26'sh1ffffff;
		r.kg = -26'sh2000000;
		send_request(r);
		r.idx = 1; r.b1 = 26'sh0100000; r.b2 = -26'sh00c0000; r.a1 = -26'sh2000000;
		r.kg = 26'sh1ffffff;
		send_request(r);
		r.idx = 2; r.last = 1'b1; r.b1 = 0; r.b2 = 0; r.a1 = 26'sh0400000; r.kg = 0;
		send_request(r);
		r = rand_fields(CMD_LOAD);
		r.idx = 10'h3ff;
		send_request(r);
		r = rand_fields(CMD_SAMPLE); r.x = 24'sh7fffff; send_request(r);
		r = rand_fields(CMD_SAMPLE); r.x = -24'sh800000; send_request(r);
		r = rand_fields(CMD_SAMPLE); r.x = 0; send_request(r);
		r = rand_fields(CMD_KICK); r.amt = -24'sh800000; send_request(r);
		r = rand_fields(CMD_KICK); r.amt = 24'sh7fffff; send_request(r);
		r = rand_fields(CMD_SAMPLE); send_request(r);
		r = rand_fields(CMD_LOAD); r.idx = 3; r.last = 1'b1; send_request(r);
		r = rand_fields(CMD_LOAD); r.idx = 1; send_request(r);
		r = rand_fields(CMD_SAMPLE); send_request(r);
		r = rand_fields(CMD_SAMPLE); send_request(r);
		r = rand_fields(CMD_CLEAR); send_request(r);
		r = rand_fields(CMD_SAMPLE); send_request(r);
		r = rand_fields(CMD_LOAD); r.idx = 0; r.last = 1'b1; send_request(r);
		r = rand_fields(CMD_SAMPLE); send_request(r);
	endtask

	// Receiver holds off while samples keep coming, so the bank backs up
	task automatic test_backpressure();
		hold_cycles = 400;
		repeat (30) send_request(rand_fields(CMD_SAMPLE));
	endtask

	// Mostly samples over well-formed coefficient lists, plus stray loads,
	// kicks and clears
	task automatic test_random(int count);
		bank_req_t r;
		int sent, pick, len, ok;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				load_list(len);
				sent += len;
			end else if (pick < 14) begin
				r = rand_fields(CMD_LOAD);
				ok = 1;
				for (int i = 0; i < r.idx; i++) if (!loaded[i]) ok = 0;
				r.last = ok && $urandom_range(0, 1);
				send_request(r);
				sent++;
			end else if (pick < 24) begin
				send_request(rand_fields(CMD_KICK));
				sent++;
			end else if (pick < 27) begin
				send_request(rand_fields(CMD_CLEAR));
				sent++;
			end else begin
				send_request(rand_fields(CMD_SAMPLE));
				sent++;
			end
		end
	endtask

	// Receiver stall pattern; long hold-off when requested
	int ready_mode, mode_left;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			res_ready <= 1'b0;
			hold_cycles--;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 80);
			end
			mode_left--;
			case (ready_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(0, 3) != 0);
				default: res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result check and watchdog
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_sums.size() == 0)
				report_mismatch($sformatf("unexpected sum %0d", sum_out));
			else if (sum_out !== expected_sums[0]) begin
				report_mismatch($sformatf("sum_out %0d, expected %0d", sum_out,
					expected_sums[0]));
				void'(expected_sums.pop_front());
			end else
				void'(expected_sums.pop_front());
		end
		if ((req_valid && req_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[two_pole_resonator_bank] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b1;
		req_valid = 1'b0;
		res_ready = 1'b0;
		cmd = CMD_SAMPLE;
		entry_index = '0;
		last_entry = 1'b0;
		feedback_one = '0;
		feedback_two = '0;
		input_gain = '0;
		kick_gain = '0;
		sample_in = '0;
		kick_amount = '0;
		errors = 0;
		burst_left = 0;
		hold_cycles = 0;
		idle_cycles = 0;
		ready_mode = 0;
		mode_left = 0;
		n_active = 0;
		vec_pos = 0;
		connected = 1'b1;
		for (int i = 0; i < NFILT; i++) begin
			loaded[i] = 1'b0;
			y_one[i] = 0;
			y_two[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_input_connected(1'b0);
		test_random(60);
		set_input_connected(1'b1);
		test_backpressure();
		test_random(200);
		set_input_connected(1'b0);
		test_random(60);
		set_input_connected(1'b1);
		test_random(200);
		drain();

		if (errors == 0)
			$display("[two_pole_resonator_bank] OK");
		else
			$display("[two_pole_resonator_bank] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tpr_pkg.sv
rtl/tpr_ram.sv
rtl/tpr_ctrl.sv
rtl/tpr_dp.sv
rtl/two_pole_resonator_bank.sv
dv/two_pole_resonator_bank_tb.sv
